// ===== hdl/hrs_pkg.sv =====
// Shared constants, register map, types and control bundles of the heart rate smoother.
package hrs_pkg;

	// Filter depths
	localparam int MEDIAN_DEPTH = 5;
	localparam int WARMUP_DEPTH = 10;
	localparam int MPOS_W = $clog2(MEDIAN_DEPTH);
	localparam int WPOS_W = $clog2(WARMUP_DEPTH);
	localparam int MCNT_W = $clog2(MEDIAN_DEPTH + 1);
	localparam int MEDIAN_MID = MEDIAN_DEPTH / 2;

	// Variance accumulator widths
	localparam int WCNT_W = $clog2(WARMUP_DEPTH + 1);
	localparam int S1_W = 16 + WCNT_W;
	localparam int S2_W = 32 + WCNT_W;
	localparam int LHS_W = S2_W + WCNT_W;
	localparam int RHS_K = WARMUP_DEPTH * WARMUP_DEPTH * 256;

	// Averaging weights, Q1.8
	localparam logic [8:0] K_TRACK = 9'd20;
	localparam logic [8:0] K_TREND = 9'd77;
	localparam logic [8:0] K_ONE = 9'd256;
	localparam logic [25:0] ROUND_HALF = 26'd128;

	// Oxygen gate
	localparam logic [6:0] OX_LOW = 7'd70;
	localparam logic [6:0] OX_HIGH = 7'd100;

	// Phase codes
	localparam logic [1:0] PH_NONE = 2'd0;
	localparam logic [1:0] PH_WARM = 2'd1;
	localparam logic [1:0] PH_MEAS = 2'd2;

	// Register map (word index)
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_JUMP_LIM = 3'd0;
	localparam logic [2:0] REG_GLITCH_ALLOW = 3'd1;
	localparam logic [2:0] REG_MIN_WARMUP = 3'd2;
	localparam logic [2:0] REG_MAX_WARMUP = 3'd3;
	localparam logic [2:0] REG_MAX_INVALID = 3'd4;
	localparam logic [2:0] REG_VAR_LIMIT = 3'd5;
	localparam logic [2:0] REG_HR_LOW = 3'd6;
	localparam logic [2:0] REG_HR_HIGH = 3'd7;

	typedef struct packed {
		logic [7:0]  jump_limit;
		logic [3:0]  glitch_allow;
		logic [15:0] min_warmup_ms;
		logic [15:0] max_warmup_ms;
		logic [4:0]  invalid_allow;
		logic [15:0] stable_variance_limit;
		logic [7:0]  hr_low_exclusive;
		logic [7:0]  hr_high_exclusive;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic classify;
		logic med;
		logic filt;
		logic var_clr;
		logic var_acc;
		logic sq;
		logic cmp;
		logic pub;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic valid_frame;
		logic warming;
		logic var_last;
	} st_t;

endpackage

// ===== hdl/hrs_cfg.sv =====
// Configuration register file with its APB-style access port.
module hrs_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hrs_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output hrs_pkg::cfg_t               cfg
);
	import hrs_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	// Write one register per access transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jump_limit <= 8'd5;
			cfg_q.glitch_allow <= 4'd2;
			cfg_q.min_warmup_ms <= 16'd15000;
			cfg_q.max_warmup_ms <= 16'd20000;
			cfg_q.invalid_allow <= 5'd15;
			cfg_q.stable_variance_limit <= 16'd1600;
			cfg_q.hr_low_exclusive <= 8'd40;
			cfg_q.hr_high_exclusive <= 8'd200;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_JUMP_LIM: cfg_q.jump_limit <= pwdata[7:0];
				REG_GLITCH_ALLOW: cfg_q.glitch_allow <= pwdata[3:0];
				REG_MIN_WARMUP: cfg_q.min_warmup_ms <= pwdata[15:0];
				REG_MAX_WARMUP: cfg_q.max_warmup_ms <= pwdata[15:0];
				REG_MAX_INVALID: cfg_q.invalid_allow <= pwdata[4:0];
				REG_VAR_LIMIT: cfg_q.stable_variance_limit <= pwdata[15:0];
				REG_HR_LOW: cfg_q.hr_low_exclusive <= pwdata[7:0];
				REG_HR_HIGH: cfg_q.hr_high_exclusive <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = 32'd0;
		unique case (paddr[4:2])
			REG_JUMP_LIM: prdata = {24'd0, cfg_q.jump_limit};
			REG_GLITCH_ALLOW: prdata = {28'd0, cfg_q.glitch_allow};
			REG_MIN_WARMUP: prdata = {16'd0, cfg_q.min_warmup_ms};
			REG_MAX_WARMUP: prdata = {16'd0, cfg_q.max_warmup_ms};
			REG_MAX_INVALID: prdata = {27'd0, cfg_q.invalid_allow};
			REG_VAR_LIMIT: prdata = {16'd0, cfg_q.stable_variance_limit};
			REG_HR_LOW: prdata = {24'd0, cfg_q.hr_low_exclusive};
			REG_HR_HIGH: prdata = {24'd0, cfg_q.hr_high_exclusive};
			default: prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/hrs_ctrl.sv =====
// Frame sequencer: steps the datapath through one frame and owns the handshakes.
module hrs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  hrs_pkg::st_t  st,
	output hrs_pkg::cmd_t cmd
);
	import hrs_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLASS = 4'd1;
	localparam logic [3:0] ST_MED = 4'd2;
	localparam logic [3:0] ST_FILT = 4'd3;
	localparam logic [3:0] ST_VAR = 4'd4;
	localparam logic [3:0] ST_SQ = 4'd5;
	localparam logic [3:0] ST_CMP = 4'd6;
	localparam logic [3:0] ST_PUB = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;

	logic [3:0] state_q, state_d;
	logic       ovalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = ST_CLASS;
				end
			end
			ST_CLASS: begin
				cmd.classify = 1'b1;
				state_d = st.valid_frame ? ST_MED : ST_OUT;
			end
			ST_MED: begin
				cmd.med = 1'b1;
				state_d = ST_FILT;
			end
			ST_FILT: begin
				cmd.filt = 1'b1;
				cmd.var_clr = 1'b1;
				state_d = st.warming ? ST_VAR : ST_PUB;
			end
			ST_VAR: begin
				cmd.var_acc = 1'b1;
				if (st.var_last) state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_PUB;
			end
			ST_PUB: begin
				cmd.pub = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!ovalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/hrs_dp.sv =====
// Datapath: frame latch, median, glitch filter, averaging, warm-up variance and outputs.
module hrs_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  hrs_pkg::cfg_t cfg,
	input  hrs_pkg::cmd_t cmd,
	output hrs_pkg::st_t  st,
	input  logic [2:0]    in_user,
	input  logic [46:0]   in_data,
	output logic [16:0]   out_data
);
	import hrs_pkg::*;

	// Latched frame
	logic        finger_q, hrv_q, oxv_q;
	logic [7:0]  rate_q;
	logic [6:0]  ox_q;
	logic [31:0] now_q;

	// Filter state
	logic [7:0]        med_q [MEDIAN_DEPTH];
	logic [MPOS_W-1:0] mpos_q;
	logic [7:0]        last_q;
	logic [3:0]        glitch_q;
	logic [15:0]       avg_q;
	logic [15:0]       wring_q [WARMUP_DEPTH];
	logic [WPOS_W-1:0] wpos_q;
	logic [31:0]       start_q;
	logic [4:0]        inv_q;
	logic [1:0]        phase_q;
	logic [7:0]        rhold_q;
	logic [6:0]        ohold_q;
	logic [7:0]        stable_q;

	// Variance work registers
	logic [WPOS_W-1:0] idx_q;
	logic [S1_W-1:0]   s1_q;
	logic [S2_W-1:0]   s2_q;
	logic [LHS_W-1:0]  s1sq_q, ds2_q;

	// Output register
	logic [7:0] orate_q;
	logic [6:0] oox_q;
	logic [1:0] ophase_q;

	logic              in_range, valid_frame, inv_reset, clear_frame;
	logic [MPOS_W-1:0] mpos_next;
	logic [WPOS_W-1:0] wpos_next;
	logic [7:0]        med_val;
	logic              med_found;
	logic [MCNT_W-1:0] cnt_lt, cnt_le;
	logic [7:0]        diff, last_n;
	logic [3:0]        glitch_n;
	logic [15:0]       avg_n;
	logic [15:0]       wx;
	logic [31:0]       elapsed;
	logic [LHS_W-1:0]  lhs, rhs;
	logic              warm_done;
	logic [16:0]       rnd;

	function automatic logic [15:0] blend(input logic [15:0] avg, input logic [7:0] r,
			input logic [8:0] k);
		logic [25:0] acc;
		acc = 26'(avg * (K_ONE - k)) + 26'({r, 8'd0} * k) + ROUND_HALF;
		return acc[23:8];
	endfunction

	// Frame classification
	assign in_range = hrv_q && (rate_q > cfg.hr_low_exclusive)
		&& (rate_q < cfg.hr_high_exclusive);
	assign valid_frame = finger_q && in_range;
	assign inv_reset = finger_q && !in_range
		&& ({1'b0, inv_q} + 6'd1 > {1'b0, cfg.invalid_allow});
	assign clear_frame = !finger_q || inv_reset;

	assign mpos_next = (mpos_q == MPOS_W'(MEDIAN_DEPTH - 1)) ? '0 : mpos_q + 1'b1;
	assign wpos_next = (wpos_q == WPOS_W'(WARMUP_DEPTH - 1)) ? '0 : wpos_q + 1'b1;

	// Median by rank: first entry with at most MID below and more than MID at or below
	always_comb begin
		med_val = '0;
		med_found = 1'b0;
		cnt_lt = '0;
		cnt_le = '0;
		for (int i = 0; i < MEDIAN_DEPTH; i++) begin
			cnt_lt = '0;
			cnt_le = '0;
			for (int j = 0; j < MEDIAN_DEPTH; j++) begin
				cnt_lt = cnt_lt + MCNT_W'(med_q[j] < med_q[i]);
				cnt_le = cnt_le + MCNT_W'(med_q[j] <= med_q[i]);
			end
			if (!med_found && cnt_lt <= MCNT_W'(MEDIAN_MID)
					&& cnt_le > MCNT_W'(MEDIAN_MID)) begin
				med_found = 1'b1;
				med_val = med_q[i];
			end
		end
	end

	// Glitch rejection and exponential average
	always_comb begin
		diff = (stable_q > last_q) ? stable_q - last_q : last_q - stable_q;
		last_n = last_q;
		glitch_n = glitch_q;
		avg_n = avg_q;
		if (last_q == 8'd0) begin
			last_n = stable_q;
			avg_n = {stable_q, 8'd0};
		end else if (diff > cfg.jump_limit) begin
			if ({1'b0, glitch_q} + 5'd1 > {1'b0, cfg.glitch_allow}) begin
				last_n = stable_q;
				avg_n = blend(avg_q, stable_q, K_TREND);
				glitch_n = '0;
			end else begin
				glitch_n = glitch_q + 4'd1;
			end
		end else begin
			glitch_n = '0;
			last_n = stable_q;
			avg_n = blend(avg_q, stable_q, K_TRACK);
		end
	end

	// Warm-up exit test
	assign wx = wring_q[idx_q];
	assign elapsed = now_q - start_q;
	assign lhs = ds2_q - s1sq_q;
	assign rhs = LHS_W'(cfg.stable_variance_limit) * LHS_W'(RHS_K);
	assign warm_done = ((elapsed > {16'd0, cfg.min_warmup_ms}) && (lhs < rhs))
		|| (elapsed > {16'd0, cfg.max_warmup_ms});
	assign rnd = {1'b0, avg_q} + 17'd128;

	assign st.valid_frame = valid_frame;
	assign st.warming = (phase_q != PH_MEAS);
	assign st.var_last = (idx_q == WPOS_W'(WARMUP_DEPTH - 1));

	assign out_data = {ophase_q, oox_q, orate_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finger_q <= 1'b0;
			hrv_q <= 1'b0;
			oxv_q <= 1'b0;
			rate_q <= '0;
			ox_q <= '0;
			now_q <= '0;
			for (int i = 0; i < MEDIAN_DEPTH; i++) med_q[i] <= '0;
			for (int i = 0; i < WARMUP_DEPTH; i++) wring_q[i] <= '0;
			mpos_q <= '0;
			last_q <= '0;
			glitch_q <= '0;
			avg_q <= '0;
			wpos_q <= '0;
			start_q <= '0;
			inv_q <= '0;
			phase_q <= PH_NONE;
			rhold_q <= '0;
			ohold_q <= '0;
			stable_q <= '0;
			idx_q <= '0;
			s1_q <= '0;
			s2_q <= '0;
			s1sq_q <= '0;
			ds2_q <= '0;
			orate_q <= '0;
			oox_q <= '0;
			ophase_q <= PH_NONE;
		end else begin
			// Capture the frame
			if (cmd.load_in) begin
				finger_q <= in_user[0];
				hrv_q <= in_user[1];
				oxv_q <= in_user[2];
				rate_q <= in_data[7:0];
				ox_q <= in_data[14:8];
				now_q <= in_data[46:15];
			end
			// Clear the filter, count an invalid frame, or push the rate
			if (cmd.classify) begin
				if (clear_frame) begin
					for (int i = 0; i < MEDIAN_DEPTH; i++) med_q[i] <= '0;
					for (int i = 0; i < WARMUP_DEPTH; i++) wring_q[i] <= '0;
					last_q <= '0;
					glitch_q <= '0;
					avg_q <= '0;
					wpos_q <= '0;
					start_q <= '0;
					inv_q <= '0;
					phase_q <= PH_NONE;
					rhold_q <= '0;
					ohold_q <= '0;
				end else if (valid_frame) begin
					inv_q <= '0;
					med_q[mpos_q] <= rate_q;
					mpos_q <= mpos_next;
				end else begin
					inv_q <= inv_q + 5'd1;
				end
			end
			// Take the median, falling back to the raw rate
			if (cmd.med) stable_q <= (med_val == 8'd0) ? rate_q : med_val;
			// Update the average and the warm-up ring, and start warm-up on the first frame
			if (cmd.filt) begin
				last_q <= last_n;
				glitch_q <= glitch_n;
				avg_q <= avg_n;
				if (phase_q == PH_NONE) begin
					phase_q <= PH_WARM;
					start_q <= now_q;
					for (int i = 0; i < MEDIAN_DEPTH; i++) med_q[i] <= stable_q;
				end
				if (phase_q != PH_MEAS) begin
					wring_q[wpos_q] <= avg_n;
					wpos_q <= wpos_next;
				end
			end
			// Accumulate sums over the warm-up ring, one entry a cycle
			if (cmd.var_clr) begin
				idx_q <= '0;
				s1_q <= '0;
				s2_q <= '0;
			end
			if (cmd.var_acc) begin
				s1_q <= s1_q + S1_W'(wx);
				s2_q <= s2_q + S2_W'(wx * wx);
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.sq) begin
				s1sq_q <= LHS_W'(s1_q * s1_q);
				ds2_q <= LHS_W'(s2_q) * LHS_W'(WARMUP_DEPTH);
			end
			if (cmd.cmp && warm_done) phase_q <= PH_MEAS;
			// Publish
			if (cmd.pub) begin
				case (phase_q)
					PH_WARM: begin
						rhold_q <= '0;
						ohold_q <= '0;
					end
					PH_MEAS: begin
						rhold_q <= rnd[16] ? 8'd255 : rnd[15:8];
						if (oxv_q && ox_q > OX_LOW && ox_q <= OX_HIGH) ohold_q <= ox_q;
					end
					default: ;
				endcase
			end
			if (cmd.load_out) begin
				orate_q <= rhold_q;
				oox_q <= ohold_q;
				ophase_q <= phase_q;
			end
		end
	end

endmodule

// ===== hdl/heart_rate_smoother.sv =====
// Top level of the heart rate smoother: config port, sequencer, datapath, checks.
// One result per frame. A frame runs from acceptance to result through classification
// alone when the finger is absent or the frame is invalid, adds median, filter and
// publish when measuring, and adds the variance walk, squaring and compare during
// warm-up, where the variance sums walk the warm-up ring one entry a cycle through a
// single 16x16 squarer. The next frame is taken once the sequencer returns to idle,
// even while the previous result still waits in the output register; a second frame
// then waits until that result is taken. The user must write configuration through the
// APB-style port only while no frame is in flight; the block does not enforce this.
module heart_rate_smoother (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [7:0] raw_rate, [14:8] oxygen_level, [46:15] time_ms, [47] zero
	input  logic [47:0]                 s_tdata,
	// [0] finger_present, [1] hr_valid, [2] oxygen_valid
	input  logic [2:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [7:0] rate_out, [14:8] oxygen_out, [16:15] phase, [23:17] zero
	output logic [23:0]                 m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hrs_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import hrs_pkg::*;

	cfg_t        cfg;
	cmd_t        cmd;
	st_t         st;
	logic [16:0] out_data;

	assign pready = 1'b1;
	assign m_tdata = {7'd0, out_data};

	hrs_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	hrs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .st(st), .cmd(cmd)
	);

	hrs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd(cmd), .st(st),
		.in_user(s_tuser), .in_data(s_tdata[46:0]), .out_data(out_data)
	);

	// Busy right after a frame is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again while a frame is in flight");

	// Warm-up and no-finger results publish zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[16:15] == PH_NONE || m_tdata[16:15] == PH_WARM)
		|-> m_tdata[14:0] == 15'd0)
		else $error("nonzero value published outside measuring");

	// Published oxygen stays at or below the gate's upper bound and the phase code is defined
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14:8] <= OX_HIGH && m_tdata[16:15] != 2'd3)
		else $error("oxygen or phase out of range");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the heart rate smoother: directed and random frames.
`timescale 1ns / 100ps

module tb;
	import hrs_pkg::*;

	typedef struct packed {
		logic [7:0] rate;
		logic [6:0] oxygen;
		logic [1:0] ph;
	} result_t;

	// Scoreboard: smoother prediction and queue of pending results
	class smoother_board;
		logic [7:0]  jump_lim = 5;
		logic [3:0]  glitch_allow = 2;
		logic [15:0] min_warm = 15000, max_warm = 20000;
		logic [4:0]  max_invalid = 15;
		logic [15:0] var_limit = 1600;
		logic [7:0]  hr_low = 40, hr_high = 200;
		logic [7:0]  med_ring [MEDIAN_DEPTH];
		int          med_pos;
		logic [7:0]  last_good;
		logic [3:0]  glitches;
		logic [15:0] avg;
		logic [15:0] warm_ring [WARMUP_DEPTH];
		int          warm_pos;
		logic [31:0] warm_start;
		logic [4:0]  invalid_run;
		logic [1:0]  ph;
		logic [7:0]  rate_hold;
		logic [6:0]  ox_hold;
		result_t     pending [$];
		int          mismatches;

		function new();
			med_pos = 0;
			mismatches = 0;
			clear_filter();
		endfunction

		function void clear_filter();
			rate_hold = 0; ox_hold = 0; avg = 0; last_good = 0; glitches = 0;
			warm_start = 0; warm_pos = 0; invalid_run = 0; ph = PH_NONE;
			foreach (warm_ring[i]) warm_ring[i] = 0;
			foreach (med_ring[i]) med_ring[i] = 0;
		endfunction

		function logic [15:0] blend(logic [15:0] a, logic [7:0] r, int k);
			longint v;
			v = (longint'(a) * (256 - k) + (longint'(r) << 8) * k + 128) >> 8;
			return v[15:0];
		endfunction

		function logic [7:0] median_push(logic [7:0] v);
			logic [7:0] s [MEDIAN_DEPTH];
			logic [7:0] t;
			med_ring[med_pos] = v;
			med_pos = (med_pos + 1) % MEDIAN_DEPTH;
			foreach (s[i]) s[i] = med_ring[i];
			for (int i = 0; i < MEDIAN_DEPTH; i++)
				for (int j = 0; j < MEDIAN_DEPTH - 1 - i; j++)
					if (s[j] > s[j+1]) begin
						t = s[j]; s[j] = s[j+1]; s[j+1] = t;
					end
			return s[MEDIAN_DEPTH/2];
		endfunction

		function bit is_stable();
			longint unsigned s1, s2, lhs, rhs;
			s1 = 0; s2 = 0;
			foreach (warm_ring[i]) begin
				s1 += warm_ring[i];
				s2 += longint'(warm_ring[i]) * warm_ring[i];
			end
			lhs = WARMUP_DEPTH * s2 - s1 * s1;
			rhs = longint'(var_limit) * WARMUP_DEPTH * WARMUP_DEPTH * 256;
			return lhs < rhs;
		endfunction

		function void advance_rate(logic [7:0] r, bit oxv, logic [6:0] ox, logic [31:0] now);
			logic [7:0]  st, d;
			logic [31:0] el;
			int          pub;
			st = median_push(r);
			if (st == 0) st = r;
			if (last_good == 0) begin
				last_good = st;
				avg = {st, 8'd0};
			end else begin
				d = st > last_good ? st - last_good : last_good - st;
				if (d > jump_lim) begin
					if (int'(glitches) + 1 > glitch_allow) begin
						last_good = st; avg = blend(avg, st, 77); glitches = 0;
					end else
						glitches++;
				end else begin
					glitches = 0; last_good = st; avg = blend(avg, st, 20);
				end
			end
			if (ph == PH_NONE) begin
				ph = PH_WARM;
				warm_start = now;
				foreach (med_ring[i]) med_ring[i] = st;
			end
			if (ph == PH_WARM) begin
				warm_ring[warm_pos] = avg;
				warm_pos = (warm_pos + 1) % WARMUP_DEPTH;
				el = now - warm_start;
				if ((el > min_warm && is_stable()) || el > max_warm) ph = PH_MEAS;
			end
			if (ph == PH_WARM) begin
				rate_hold = 0; ox_hold = 0;
			end else if (ph == PH_MEAS) begin
				pub = (int'(avg) + 128) >> 8;
				rate_hold = pub > 255 ? 8'd255 : pub[7:0];
				if (oxv && ox > OX_LOW && ox <= OX_HIGH) ox_hold = ox;
			end
		endfunction

		function void note_frame(logic [2:0] flags, logic [47:0] d);
			if (!flags[0])
				clear_filter();
			else if (flags[1] && d[7:0] > hr_low && d[7:0] < hr_high) begin
				invalid_run = 0;
				advance_rate(d[7:0], flags[2], d[14:8], d[46:15]);
			end else if (int'(invalid_run) + 1 > max_invalid)
				clear_filter();
			else
				invalid_run++;
			pending.push_back('{rate_hold, ox_hold, ph});
		endfunction

		function void check_result(logic [23:0] d);
			result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", d);
				return;
			end
			e = pending.pop_front();
			if (d[7:0] !== e.rate || d[14:8] !== e.oxygen || d[16:15] !== e.ph
					|| d[23:17] !== 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: rate %0d/%0d oxygen %0d/%0d phase %0d/%0d",
						e.rate, d[7:0], e.oxygen, d[14:8], e.ph, d[16:15]);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, psel, penable, pwrite, pready;
	logic [47:0] s_tdata;
	logic [2:0] s_tuser;
	logic [23:0] m_tdata;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	smoother_board board;
	logic [31:0] clock_ms;
	int hold_off;
	bit stall_long;

	heart_rate_smoother dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Give up after a generous fixed time
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	function int pick_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 19) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 3);
	endfunction

	// Check every result transaction; stall the receiver at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else if (stall_long) begin
			stall_long <= 1'b0;
			hold_off <= 300;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			hold_off <= pick_gap();
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_JUMP_LIM:     board.jump_lim = v[7:0];
			REG_GLITCH_ALLOW: board.glitch_allow = v[3:0];
			REG_MIN_WARMUP:   board.min_warm = v[15:0];
			REG_MAX_WARMUP:   board.max_warm = v[15:0];
			REG_MAX_INVALID:  board.max_invalid = v[4:0];
			REG_VAR_LIMIT:    board.var_limit = v[15:0];
			REG_HR_LOW:       board.hr_low = v[7:0];
			default:          board.hr_high = v[7:0];
		endcase
	endtask

	// Offer one frame; tvalid stays up after the transaction until the next call or drain
	task automatic send_frame(logic [2:0] flags, logic [7:0] r, logic [6:0] ox,
			logic [31:0] t);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1; s_tuser <= flags; s_tdata <= {1'b0, t, ox, r};
		do @(posedge clk); while (!s_tready);
		board.note_frame(flags, {1'b0, t, ox, r});
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Mostly well-formed measuring sessions with some noise
	task automatic run_session(int n);
		logic [7:0] base;
		logic [2:0] f;
		logic [7:0] r;
		base = 8'($urandom_range(50, 150));
		for (int i = 0; i < n; i++) begin
			clock_ms += $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(100, 400);
			f = 3'b011 | ($urandom_range(0, 3) != 0 ? 3'b100 : 3'b000);
			r = 8'(base + $urandom_range(0, 6) - 3);
			case ($urandom_range(0, 19))
				0: f[0] = 0;
				1: f[1] = 0;
				2: r = 8'($urandom);
				3: r = 8'(base + $urandom_range(10, 40));
				default: ;
			endcase
			send_frame(f, r,
				7'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(60, 100)),
				clock_ms);
		end
	endtask

	initial begin
		logic [7:0] dr [6];
		board = new();
		arst_n = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		hold_off = 0; stall_long = 0; clock_ms = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		// Directed: short warm-up limits, edge rates and oxygen gate
		write_reg(REG_MIN_WARMUP, 0);
		write_reg(REG_MAX_WARMUP, 1000);
		dr = '{8'd0, 8'd255, 8'd40, 8'd41, 8'd199, 8'd200};
		foreach (dr[i]) send_frame(3'b011, dr[i], 7'd0, 32'(i * 300));
		send_frame(3'b111, 8'd80, 7'd70, 32'hFFFF_FF00);
		send_frame(3'b111, 8'd80, 7'd71, 32'd500);
		send_frame(3'b111, 8'd80, 7'd100, 32'd900);
		send_frame(3'b111, 8'd80, 7'd101, 32'd1500);
		send_frame(3'b111, 8'd80, 7'd127, 32'd1900);
		send_frame(3'b101, 8'd80, 7'd90, 32'd2000);
		send_frame(3'b000, 8'd80, 7'd90, 32'd2100);
		for (int i = 0; i < 18; i++) send_frame(3'b001, 8'd90, 7'd90, 32'd2200);
		drain();
		// Random phases over several settings, extremes included
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					write_reg(REG_JUMP_LIM, 0); write_reg(REG_GLITCH_ALLOW, 0);
					write_reg(REG_MAX_INVALID, 0); write_reg(REG_VAR_LIMIT, 0);
				end
				1: begin
					write_reg(REG_JUMP_LIM, 255); write_reg(REG_GLITCH_ALLOW, 15);
					write_reg(REG_MAX_INVALID, 31); write_reg(REG_VAR_LIMIT, 16'hFFFF);
					write_reg(REG_MIN_WARMUP, 16'hFFFF); write_reg(REG_MAX_WARMUP, 16'hFFFF);
				end
				2: begin
					write_reg(REG_HR_LOW, 0); write_reg(REG_HR_HIGH, 255);
					write_reg(REG_MIN_WARMUP, 2000); write_reg(REG_MAX_WARMUP, 0);
				end
				3: begin
					write_reg(REG_HR_LOW, 255); write_reg(REG_HR_HIGH, 0);
				end
				default: begin
					write_reg(REG_JUMP_LIM, $urandom_range(0, 12));
					write_reg(REG_GLITCH_ALLOW, $urandom_range(0, 4));
					write_reg(REG_MIN_WARMUP, $urandom_range(0, 4000));
					write_reg(REG_MAX_WARMUP, $urandom_range(2000, 8000));
					write_reg(REG_MAX_INVALID, $urandom_range(0, 31));
					write_reg(REG_VAR_LIMIT, $urandom_range(0, 3000));
					write_reg(REG_HR_LOW, 40); write_reg(REG_HR_HIGH, 200);
				end
			endcase
			if (p == 2) stall_long = 1;
			for (int s = 0; s < 5; s++) run_session($urandom_range(10, 70));
			drain();
		end
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
